[rtl/sorted_key_table_top_macros.svh]
// ----------------------------------------------------------------------------
// sorted_key_table_top_macros.svh
// Assertion macros shared by the sorted key table RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_TOP_MACROS_SVH
`define SORTED_KEY_TABLE_TOP_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define SKT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_key_table: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define SKT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_key_table: next-cycle check failed");

`endif

[rtl/skt_pkg.sv]
// ----------------------------------------------------------------------------
// skt_pkg
// Types and constants of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 64;
  localparam int VAL_W    = 64;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NULL = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  typedef struct packed {
    logic             opcode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] entry_value;
  } req_item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [VAL_W-1:0] found_value;
  } rsp_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

[rtl/skt_ram.sv]
// ----------------------------------------------------------------------------
// skt_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/sorted_key_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_key_table_top
// Table of key/value pairs kept in ascending unsigned key order, with insert
// into place and binary-search lookup. Each request item gives one response
// item. An insert walks down from the top of the table one entry per cycle,
// moving each entry whose key is not smaller up one slot until it finds its
// place. Each lookup probe is a memory read, then a compare. Rejected inserts
// and null or empty lookups go straight to the response state. Pairs live in
// one RAM with a single read and a single write port; no clearing pass is
// needed after reset. A new request is taken as soon as the previous
// response sits in the output register.
// ----------------------------------------------------------------------------
`include "sorted_key_table_top_macros.svh"

module sorted_key_table_top
  import skt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  input  req_item_t req,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output rsp_item_t rsp
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INS    = 5'b00010,
    S_LK_RD  = 5'b00100,
    S_LK_CHK = 5'b01000,
    S_RESP   = 5'b10000
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        ptr;
  logic signed [CNT_W:0]   lo;
  logic signed [CNT_W:0]   hi;
  logic [IDX_W-1:0]        mid;
  req_item_t               cur;
  rsp_item_t               res;

  logic                    we;
  logic [IDX_W-1:0]        waddr;
  entry_t                  wdata;
  logic [IDX_W-1:0]        raddr;
  entry_t                  rdata;

  logic [CNT_W-1:0]        count_m1;
  logic [CNT_W-1:0]        ptr_m1;
  logic [CNT_W-1:0]        ptr_m2;
  logic signed [CNT_W:0]   span;
  logic signed [CNT_W:0]   mid_calc;
  logic signed [CNT_W:0]   mid_ext;
  logic                    req_fire;

  assign req_ready = (state == S_IDLE);
  assign req_fire  = req_valid && req_ready;

  assign count_m1 = count - CNT_W'(1);
  assign ptr_m1   = ptr - CNT_W'(1);
  assign ptr_m2   = ptr - CNT_W'(2);
  assign span     = hi - lo;
  assign mid_calc = lo + (span >>> 1);
  assign mid_ext  = (CNT_W + 1)'(mid);

  skt_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Read address: the walk-down pre-reads the next lower entry each cycle.
  always_comb begin
    unique case (state)
      S_IDLE:  raddr = count_m1[IDX_W-1:0];
      S_INS:   raddr = ptr_m2[IDX_W-1:0];
      S_LK_RD: raddr = mid_calc[IDX_W-1:0];
      default: raddr = mid;
    endcase
  end

  // Insert write: either the new pair lands in slot ptr, or the entry below
  // moves up into it.
  always_comb begin
    we          = 1'b0;
    waddr       = ptr[IDX_W-1:0];
    wdata.key   = cur.key;
    wdata.value = cur.entry_value;
    if (state == S_INS) begin
      we = 1'b1;
      if (ptr != '0 && !(rdata.key < cur.key)) begin
        wdata = rdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // In S_RESP the output register is reloaded below instead.
      if (rsp_valid && rsp_ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_fire) begin
            cur             <= req;
            ptr             <= count;
            lo              <= '0;
            hi              <= (CNT_W + 1)'(count) - (CNT_W + 1)'(1);
            res.found_value <= '0;
            if (req.opcode == OP_INSERT) begin
              if (req.key == '0 || req.entry_value == '0) begin
                res.status <= ST_NULL;
                state      <= S_RESP;
              end else if (count == CNT_W'(CAPACITY)) begin
                res.status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                state <= S_INS;
              end
            end else begin
              if (req.key == '0 || count == '0) begin
                res.status <= ST_MISS;
                state      <= S_RESP;
              end else begin
                state <= S_LK_RD;
              end
            end
          end
        end
        S_INS: begin
          if (ptr == '0 || rdata.key < cur.key) begin
            count      <= count + CNT_W'(1);
            res.status <= ST_OK;
            state      <= S_RESP;
          end else begin
            ptr <= ptr_m1;
          end
        end
        S_LK_RD: begin
          if (lo <= hi) begin
            mid   <= mid_calc[IDX_W-1:0];
            state <= S_LK_CHK;
          end else begin
            res.status <= ST_MISS;
            state      <= S_RESP;
          end
        end
        S_LK_CHK: begin
          if (rdata.key == cur.key) begin
            res.status      <= ST_OK;
            res.found_value <= rdata.value;
            state           <= S_RESP;
          end else begin
            if (rdata.key < cur.key) begin
              lo <= mid_ext + (CNT_W + 1)'(1);
            end else begin
              hi <= mid_ext - (CNT_W + 1)'(1);
            end
            state <= S_LK_RD;
          end
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp       <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `SKT_ASSERT_NOW(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(CAPACITY))
  `SKT_ASSERT_NOW(a_ptr_bound, clk, rst, state == S_INS, ptr <= count)
  `SKT_ASSERT_NOW(a_we_only_insert, clk, rst, we, state == S_INS)
  `SKT_ASSERT_NEXT(a_fire_leaves_idle, clk, rst, req_fire, state != S_IDLE)
  `SKT_ASSERT_NEXT(a_resp_loads, clk, rst, state == S_RESP && (!rsp_valid || rsp_ready),
                   rsp_valid && state == S_IDLE)

endmodule

[verif/sorted_key_table_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_key_table_checker
// Watches the request and response channels of the sorted key table. It
// keeps its own sorted copy of the table to work out the response to each
// accepted request, and compares every accepted response, field by field,
// with the oldest pending prediction.
// ----------------------------------------------------------------------------
module sorted_key_table_checker
  import skt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_ready,
  input  req_item_t req,
  input  logic      rsp_valid,
  input  logic      rsp_ready,
  input  rsp_item_t rsp,
  output int        mismatches,
  output int        outstanding,
  output int        peak_fill,
  output int        lookup_hits
);

  logic [KEY_W-1:0] key_copy [CAPACITY];
  logic [VAL_W-1:0] value_copy [CAPACITY];
  int               fill;
  rsp_item_t        pending_rsps [$];

  function automatic rsp_item_t table_insert(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    rsp_item_t result;
    int        pos;
    result.found_value = '0;
    if (k == '0 || v == '0) begin
      result.status = ST_NULL;
    end else if (fill >= CAPACITY) begin
      result.status = ST_FULL;
    end else begin
      // The new pair goes ahead of any entries with an equal key.
      pos = 0;
      while (pos < fill && key_copy[pos] < k) pos++;
      for (int i = fill; i > pos; i--) begin
        key_copy[i]   = key_copy[i-1];
        value_copy[i] = value_copy[i-1];
      end
      key_copy[pos]   = k;
      value_copy[pos] = v;
      fill++;
      if (fill > peak_fill) peak_fill = fill;
      result.status = ST_OK;
    end
    return result;
  endfunction

  function automatic rsp_item_t table_lookup(logic [KEY_W-1:0] k);
    rsp_item_t result;
    int        lo;
    int        hi;
    int        mid;
    result.status      = ST_MISS;
    result.found_value = '0;
    if (k != '0 && fill != 0) begin
      lo = 0;
      hi = fill - 1;
      // With duplicates, the answer is whichever equal entry the probes hit first.
      while (lo <= hi) begin
        mid = lo + (hi - lo) / 2;
        if (key_copy[mid] == k) begin
          result.status      = ST_OK;
          result.found_value = value_copy[mid];
          lookup_hits++;
          break;
        end
        if (key_copy[mid] < k) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    return result;
  endfunction

  task automatic report(string what, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s differs: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      fill = 0;
      peak_fill = 0;
      lookup_hits = 0;
      mismatches = 0;
      pending_rsps.delete();
      outstanding <= 0;
    end else begin
      // The response register never holds the item accepted at this same edge,
      // so the response is matched before the new request is predicted.
      if (rsp_valid && rsp_ready) begin
        if (pending_rsps.size() == 0) begin
          report("response with none pending, found_value", '0, rsp.found_value);
        end else begin
          want = pending_rsps.pop_front();
          if (rsp.status != want.status) begin
            report("status", VAL_W'(want.status), VAL_W'(rsp.status));
          end
          if (rsp.found_value != want.found_value) begin
            report("found_value", want.found_value, rsp.found_value);
          end
        end
      end
      if (req_valid && req_ready) begin
        if (req.opcode == OP_INSERT) begin
          pending_rsps.push_back(table_insert(req.key, req.entry_value));
        end else begin
          pending_rsps.push_back(table_lookup(req.key));
        end
      end
      outstanding <= pending_rsps.size();
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the sorted key table with a short directed sequence (empty table,
// null keys and values, extreme keys, duplicates) and then with random
// inserts and lookups that fill the table to capacity and beyond. Both
// channels idle at random; a separate checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import skt_pkg::*;

  localparam int IDLE_LIMIT = 4000;

  logic      clk;
  logic      rst       = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req       = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  int mismatches;
  int outstanding;
  int peak_fill;
  int lookup_hits;

  logic send_quiet = 1'b0;
  logic rsp_quiet  = 1'b0;
  int   rsp_wait   = 0;
  int   idle_cycles = 0;
  int   inserts_sent = 0;
  int   lookups_sent = 0;
  logic [KEY_W-1:0] inserted_keys [$];

  sorted_key_table_top uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  sorted_key_table_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .peak_fill   (peak_fill),
    .lookup_hits (lookup_hits)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Response side: after each accepted item, hold ready low for a random stall.
  always @(posedge clk) begin
    int stall;
    if (rst) begin
      rsp_ready <= 1'b0;
      rsp_wait  <= 0;
    end else if (rsp_ready) begin
      if (rsp_valid) begin
        stall = rsp_quiet ? 0 : $urandom_range(0, 11);
        if (stall != 0) begin
          rsp_ready <= 1'b0;
          rsp_wait  <= stall - 1;
        end
      end
    end else if (rsp_wait == 0) begin
      rsp_ready <= 1'b1;
    end else begin
      rsp_wait <= rsp_wait - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2: return KEY_W'($urandom_range(1, 24));
      3: begin
        case ($urandom_range(0, 3))
          0:       return KEY_W'(1);
          1:       return '1;
          2:       return {1'b1, {(KEY_W-1){1'b0}}};
          default: return {1'b0, {(KEY_W-1){1'b1}}};
        endcase
      end
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_item(logic op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    req_item_t item;
    int        gap;
    item.opcode      = op;
    item.key         = k;
    item.entry_value = v;
    gap = send_quiet ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    if (op == OP_INSERT) begin
      inserts_sent++;
      if (k != '0 && v != '0) inserted_keys.push_back(k);
    end else begin
      lookups_sent++;
    end
  endtask

  // Stop sending until every predicted response has been accepted.
  task automatic drain_responses();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int               insert_pct;
    int               sel;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: empty table, null operands, extreme keys, duplicates.
    send_item(OP_LOOKUP, 64'd5, '1);
    send_item(OP_LOOKUP, '0, '0);
    send_item(OP_INSERT, '0, 64'd7);
    send_item(OP_INSERT, 64'd7, '0);
    send_item(OP_INSERT, '0, '0);
    send_item(OP_INSERT, '1, '1);
    send_item(OP_INSERT, 64'd1, 64'd1);
    send_item(OP_INSERT, 64'h8000_0000_0000_0000, 64'h0123_4567_89ab_cdef);
    send_item(OP_INSERT, 64'd100, 64'hA);
    send_item(OP_INSERT, 64'd100, 64'hB);
    send_item(OP_INSERT, 64'd100, 64'hC);
    send_item(OP_LOOKUP, 64'd100, '0);
    send_item(OP_LOOKUP, 64'd1, '0);
    send_item(OP_LOOKUP, '1, '0);
    send_item(OP_LOOKUP, '0, '1);
    send_item(OP_LOOKUP, 64'd50, '0);
    send_item(OP_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFE, '0);
    send_item(OP_LOOKUP, 64'h8000_0000_0000_0000, '0);
    send_item(OP_INSERT, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_item(OP_LOOKUP, 64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    send_item(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_item(OP_LOOKUP, 64'hAAAA_AAAA_AAAA_AAAA, '0);
    drain_responses();

    // Random part: mostly inserts early on so the table fills up, then mostly
    // lookups with inserts that hit the full table.
    for (int n = 0; n < 730; n++) begin
      if (n % 40 == 0) begin
        send_quiet = ($urandom_range(0, 3) == 0);
        rsp_quiet <= ($urandom_range(0, 3) == 0);
      end
      if (n % 150 == 149) drain_responses();
      insert_pct = (n < 400) ? 65 : 25;
      if ($urandom_range(0, 99) < insert_pct) begin
        k = ($urandom_range(0, 19) == 0) ? '0 : pick_key();
        case ($urandom_range(0, 24))
          0, 1:    v = '0;
          2:       v = '1;
          3:       v = VAL_W'(1);
          default: v = {$urandom, $urandom};
        endcase
        send_item(OP_INSERT, k, v);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 5 && inserted_keys.size() > 0) begin
          k = inserted_keys[$urandom_range(inserted_keys.size() - 1, 0)];
        end else if (sel == 5) begin
          k = '0;
        end else begin
          k = pick_key();
        end
        send_item(OP_LOOKUP, k, {$urandom, $urandom});
      end
    end

    drain_responses();
    repeat (20) @(posedge clk);

    $display("Drove %0d inserts and %0d lookups with random idle gaps on both channels.",
             inserts_sent, lookups_sent);
    $display("Table peaked at %0d of %0d entries; %0d lookups matched a stored key.",
             peak_fill, CAPACITY, lookup_hits);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
